FILE: rtl/circle_pushout_vector_top_macros.svh
// assertion macros for the circle push-out block
`ifndef CIRCLE_PUSHOUT_VECTOR_TOP_MACROS_SVH
`define CIRCLE_PUSHOUT_VECTOR_TOP_MACROS_SVH

// same-cycle implication, clocked on clk, off during rst
`define CPV_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during rst
`define CPV_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/cpv_pkg.sv
// shared constants of the circle push-out block
package cpv_pkg;
  localparam int COORD_BITS_DEF = 24;
  localparam int FRAC_BITS_DEF  = 8;
  localparam int MARGIN_BITS    = 16;
  localparam int OUT_BITS       = 32;
  localparam logic [MARGIN_BITS-1:0] MARGIN_RESET = 16'd364;
  localparam logic [OUT_BITS-1:0] OUT_MAX = 32'h7FFF_FFFF;
  localparam logic [OUT_BITS-1:0] OUT_MIN_MAG = 32'h8000_0000;
endpackage

FILE: rtl/cpv_sqrt.sv
// pipelined integer square root, one root bit per stage
module cpv_sqrt #(
  parameter int RW = 48,
  parameter int PW = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [RW-1:0]       in_rad,
  input  logic [PW-1:0]       in_pay,
  output logic                out_valid,
  output logic [RW/2-1:0]     out_root,
  output logic [PW-1:0]       out_pay
);
  localparam int N = RW / 2;

  logic          vld  [1:N];
  logic [RW-1:0] rad  [1:N];
  logic [N+1:0]  rem  [1:N];
  logic [N-1:0]  root [1:N];
  logic [PW-1:0] pay  [1:N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic          c_vld;
    logic [RW-1:0] c_rad;
    logic [N+1:0]  c_rem;
    logic [N-1:0]  c_root;
    logic [PW-1:0] c_pay;
    logic [N+1:0]  sh;
    logic [N+1:0]  trial;
    logic          ge;

    if (i == 0) begin : g_first
      assign c_vld  = in_valid;
      assign c_rad  = in_rad;
      assign c_rem  = '0;
      assign c_root = '0;
      assign c_pay  = in_pay;
    end else begin : g_mid
      assign c_vld  = vld[i];
      assign c_rad  = rad[i];
      assign c_rem  = rem[i];
      assign c_root = root[i];
      assign c_pay  = pay[i];
    end

    always_comb begin
      sh    = {c_rem[N-1:0], c_rad[RW-1:RW-2]};
      trial = {c_root, 2'b01};
      ge    = (sh >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= c_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad[i+1]  <= c_rad << 2;
        rem[i+1]  <= ge ? (sh - trial) : sh;
        root[i+1] <= {c_root[N-2:0], ge};
        pay[i+1]  <= c_pay;
      end
    end
  end

  assign out_valid = vld[N];
  assign out_root  = root[N];
  assign out_pay   = pay[N];
endmodule

FILE: rtl/cpv_div.sv
// pipelined unsigned restoring divider, one quotient bit per stage
module cpv_div #(
  parameter int DW = 49,
  parameter int MW = 24,
  parameter int PW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [DW-1:0] in_dvd,
  input  logic [MW-1:0] in_dvs,
  input  logic [PW-1:0] in_pay,
  output logic          out_valid,
  output logic [DW-1:0] out_quo,
  output logic [PW-1:0] out_pay
);
  logic          vld [1:DW];
  logic [DW-1:0] dvd [1:DW];
  logic [MW-1:0] dvs [1:DW];
  logic [MW-1:0] rem [1:DW];
  logic [PW-1:0] pay [1:DW];

  for (genvar i = 0; i < DW; i++) begin : g_stage
    logic          c_vld;
    logic [DW-1:0] c_dvd;
    logic [MW-1:0] c_dvs;
    logic [MW-1:0] c_rem;
    logic [PW-1:0] c_pay;
    logic [MW:0]   sh;
    logic [MW:0]   diff;
    logic          ge;

    if (i == 0) begin : g_first
      assign c_vld = in_valid;
      assign c_dvd = in_dvd;
      assign c_dvs = in_dvs;
      assign c_rem = '0;
      assign c_pay = in_pay;
    end else begin : g_mid
      assign c_vld = vld[i];
      assign c_dvd = dvd[i];
      assign c_dvs = dvs[i];
      assign c_rem = rem[i];
      assign c_pay = pay[i];
    end

    always_comb begin
      sh   = {c_rem, c_dvd[DW-1]};
      diff = sh - {1'b0, c_dvs};
      ge   = (sh >= {1'b0, c_dvs});
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= c_vld;
      end
    end

    // quotient bits shift in behind the dividend
    always_ff @(posedge clk) begin
      if (en) begin
        dvd[i+1] <= {c_dvd[DW-2:0], ge};
        dvs[i+1] <= c_dvs;
        rem[i+1] <= ge ? diff[MW-1:0] : sh[MW-1:0];
        pay[i+1] <= c_pay;
      end
    end
  end

  assign out_valid = vld[DW];
  assign out_quo   = dvd[DW];
  assign out_pay   = pay[DW];
endmodule

FILE: rtl/circle_pushout_vector_top.sv
// throughput: one item per cycle while the skid entry is empty, set by the fully pipelined root and divider stages
// output register plus skid entry; the pipeline stalls as a whole when the skid fills
// rst is synchronous: clears valid bits and sets push_margin to 364
// top level of the circle push-out vector pipeline
module circle_pushout_vector_top #(
  parameter int COORD_BITS = cpv_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = cpv_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // point_x, point_y, velocity_x, velocity_y, circle_x, circle_y,
  // circle_radius, source_radius, zero pad
  input  logic [((8*COORD_BITS-2+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // push_x, push_y
  output logic [2*cpv_pkg::OUT_BITS-1:0] m_axis_tdata,
  // hit
  output logic m_axis_tuser,
  input  logic cfg_wr_en,
  input  logic [cpv_pkg::MARGIN_BITS-1:0] cfg_wr_data
);
  `include "circle_pushout_vector_top_macros.svh"

  localparam int C   = COORD_BITS;
  localparam int OB  = cpv_pkg::OUT_BITS;
  localparam int MSH = (FRAC_BITS >= 8) ? FRAC_BITS - 8 : 0;
  localparam int RSH = (FRAC_BITS < 8) ? 8 - FRAC_BITS : 0;
  localparam int MGW = cpv_pkg::MARGIN_BITS + MSH;
  localparam int TW  = ((C + 3 > MGW) ? C + 3 : MGW) + 1;
  localparam int QW  = C + TW;
  localparam int SW  = (QW > OB + 1) ? QW : OB + 1;
  localparam int P1W = 6*C + 3;
  localparam int P2W = 5*C + 2;
  localparam int P3W = 4*C + 3;

  logic en;
  logic [cpv_pkg::MARGIN_BITS-1:0] push_margin;
  logic [MGW-1:0] margin;

  always_ff @(posedge clk) begin
    if (rst) begin
      push_margin <= cpv_pkg::MARGIN_RESET;
    end else if (cfg_wr_en) begin
      push_margin <= cfg_wr_data;
    end
  end

  assign margin = (FRAC_BITS >= 8) ? (MGW'(push_margin) << MSH)
                                   : MGW'(push_margin >> RSH);

  // input unpack
  logic signed [C-1:0] px, py, vx, vy, cx, cy;
  logic [C-2:0] rc, rs;
  assign px = s_axis_tdata[C-1:0];
  assign py = s_axis_tdata[2*C-1:C];
  assign vx = s_axis_tdata[3*C-1:2*C];
  assign vy = s_axis_tdata[4*C-1:3*C];
  assign cx = s_axis_tdata[5*C-1:4*C];
  assign cy = s_axis_tdata[6*C-1:5*C];
  assign rc = s_axis_tdata[7*C-2:6*C];
  assign rs = s_axis_tdata[8*C-3:7*C-1];

  assign s_axis_tready = en;

  // stage 1: offsets and summed radius
  logic v1;
  logic signed [C:0] dx1, dy1;
  logic [C-1:0] r1;
  logic signed [C-1:0] vx1, vy1;

  // stage 2: products
  logic v2;
  logic signed [2*C+1:0] pxx2, pyy2;
  logic [2*C-1:0] prr2;
  logic signed [2*C-1:0] pvx2, pvy2;
  logic signed [2*C:0] phx2, phy2;
  logic signed [C-1:0] vx2, vy2;

  // stage 3: sums
  logic v3;
  logic [2*C+1:0] d2_3;
  logic [2*C-1:0] r2_3;
  logic [2*C-1:0] a3;
  logic signed [2*C+1:0] hu3;
  logic signed [C-1:0] vx3, vy3;

  // stage 4: compare, k, |h|
  logic v4;
  logic [2*C-1:0] a4;
  logic [P1W-1:0] pay4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= s_axis_tvalid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx1  <= (C+1)'(px) - (C+1)'(cx);
      dy1  <= (C+1)'(py) - (C+1)'(cy);
      r1   <= C'(rc) + C'(rs);
      vx1  <= vx;
      vy1  <= vy;

      pxx2 <= (2*C+2)'(dx1) * (2*C+2)'(dx1);
      pyy2 <= (2*C+2)'(dy1) * (2*C+2)'(dy1);
      prr2 <= (2*C)'(r1) * (2*C)'(r1);
      pvx2 <= (2*C)'(vx1) * (2*C)'(vx1);
      pvy2 <= (2*C)'(vy1) * (2*C)'(vy1);
      phx2 <= (2*C+1)'(vx1) * (2*C+1)'(dx1);
      phy2 <= (2*C+1)'(vy1) * (2*C+1)'(dy1);
      vx2  <= vx1;
      vy2  <= vy1;

      d2_3 <= $unsigned(pxx2 + pyy2);
      r2_3 <= prr2;
      a3   <= $unsigned(pvx2) + $unsigned(pvy2);
      hu3  <= (2*C+2)'(phx2) + (2*C+2)'(phy2);
      vx3  <= vx2;
      vy3  <= vy2;
    end
  end

  logic           far4, eq4, hneg4, zero4;
  logic [2*C-1:0] k4;
  logic [2*C:0]   hm4;

  always_comb begin
    far4  = d2_3 > (2*C+2)'(r2_3);
    eq4   = d2_3 == (2*C+2)'(r2_3);
    k4    = r2_3 - d2_3[2*C-1:0];
    hneg4 = hu3[2*C+1];
    hm4   = hneg4 ? (2*C+1)'($unsigned(-hu3)) : (2*C+1)'($unsigned(hu3));
    zero4 = far4 || (a3 == '0) || ((hu3 == '0) && eq4);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a4   <= a3;
      pay4 <= {hm4, k4, hneg4, zero4, vx3, vy3};
    end
  end

  // |v| root
  logic           v_s1;
  logic [C-1:0]   mag_s1;
  logic [P1W-1:0] pay_s1;

  cpv_sqrt #(.RW(2*C), .PW(P1W)) u_sqrt_mag (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v4),
    .in_rad    (a4),
    .in_pay    (pay4),
    .out_valid (v_s1),
    .out_root  (mag_s1),
    .out_pay   (pay_s1)
  );

  // p = |h| / mag
  logic           v_d1;
  logic [2*C:0]   quo_d1;
  logic [P2W-1:0] pay_d1;

  cpv_div #(.DW(2*C+1), .MW(C), .PW(P2W)) u_div_p (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v_s1),
    .in_dvd    (pay_s1[P1W-1:P1W-2*C-1]),
    .in_dvs    (mag_s1),
    .in_pay    ({pay_s1[4*C+1:0], mag_s1}),
    .out_valid (v_d1),
    .out_quo   (quo_d1),
    .out_pay   (pay_d1)
  );

  // pay_d1: k, hneg, zero, vx, vy, mag
  logic v5, v6;
  logic [C:0] pm5, pm6;
  logic [2*C+1:0] pm2_5;
  logic [2*C-1:0] k5;
  logic [3*C+1:0] rest5, rest6;
  logic [2*C+3:0] rad6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (en) begin
      v5 <= v_d1;
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pm5   <= quo_d1[C:0];
      pm2_5 <= (2*C+2)'(quo_d1[C:0]) * (2*C+2)'(quo_d1[C:0]);
      k5    <= pay_d1[P2W-1:P2W-2*C];
      rest5 <= pay_d1[3*C+1:0];
      pm6   <= pm5;
      rad6  <= (2*C+4)'(pm2_5) + (2*C+4)'(k5);
      rest6 <= rest5;
    end
  end

  // s = sqrt(p^2 + k)
  logic           v_s2;
  logic [C+1:0]   s_s2;
  logic [P3W-1:0] pay_s2;

  cpv_sqrt #(.RW(2*C+4), .PW(P3W)) u_sqrt_s (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v6),
    .in_rad    (rad6),
    .in_pay    ({pm6, rest6}),
    .out_valid (v_s2),
    .out_root  (s_s2),
    .out_pay   (pay_s2)
  );

  // pay_s2: pm, hneg, zero, vx, vy, mag
  logic [C:0]   pm_s2;
  logic         hneg_s2;
  assign pm_s2   = pay_s2[P3W-1:3*C+2];
  assign hneg_s2 = pay_s2[3*C+1];

  logic v7, v8, v9;
  logic [C+2:0] dist7;
  logic [TW-1:0] total8;
  logic [3*C:0] rest7, rest8;
  logic [QW-1:0] prx9, pry9;
  logic [C-1:0] mag9;
  logic zero9, sx9, sy9;
  logic signed [C-1:0] vx8, vy8;
  logic [C-1:0] avx8, avy8;

  assign vx8  = rest8[3*C-1:2*C];
  assign vy8  = rest8[2*C-1:C];
  assign avx8 = $unsigned(vx8[C-1] ? -vx8 : vx8);
  assign avy8 = $unsigned(vy8[C-1] ? -vy8 : vy8);

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
      v8 <= 1'b0;
      v9 <= 1'b0;
    end else if (en) begin
      v7 <= v_s2;
      v8 <= v7;
      v9 <= v8;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (hneg_s2) begin
        dist7 <= ((C+2)'(s_s2) > (C+2)'(pm_s2)) ?
                 (C+3)'((C+2)'(s_s2) - (C+2)'(pm_s2)) : '0;
      end else begin
        dist7 <= (C+3)'(s_s2) + (C+3)'(pm_s2);
      end
      rest7  <= pay_s2[3*C:0];
      total8 <= TW'(dist7) + TW'(margin);
      rest8  <= rest7;
      prx9   <= QW'(avx8) * QW'(total8);
      pry9   <= QW'(avy8) * QW'(total8);
      mag9   <= rest8[C-1:0];
      zero9  <= rest8[3*C];
      sx9    <= vx8[C-1];
      sy9    <= vy8[C-1];
    end
  end

  // push magnitudes over mag
  logic          v_dx, v_dy;
  logic [QW-1:0] qx, qy;
  logic [1:0]    pay_dx;
  logic          pay_dy;

  cpv_div #(.DW(QW), .MW(C), .PW(2)) u_div_x (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v9),
    .in_dvd    (prx9),
    .in_dvs    (mag9),
    .in_pay    ({zero9, sx9}),
    .out_valid (v_dx),
    .out_quo   (qx),
    .out_pay   (pay_dx)
  );

  cpv_div #(.DW(QW), .MW(C), .PW(1)) u_div_y (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v9),
    .in_dvd    (pry9),
    .in_dvs    (mag9),
    .in_pay    (sy9),
    .out_valid (v_dy),
    .out_quo   (qy),
    .out_pay   (pay_dy)
  );

  function automatic logic [OB-1:0] sat_push(input logic [SW-1:0] q, input logic neg);
    logic [OB-1:0] m;
    if (neg) begin
      sat_push = (q > SW'(cpv_pkg::OUT_MAX)) ? cpv_pkg::OUT_MAX : q[OB-1:0];
    end else begin
      m = (q > SW'(cpv_pkg::OUT_MIN_MAG)) ? cpv_pkg::OUT_MIN_MAG : q[OB-1:0];
      sat_push = ~m + OB'(1);
    end
  endfunction

  // final stage, output register and skid entry
  logic          fv;
  logic [2*OB:0] fd;
  logic          skid_valid;
  logic [2*OB:0] skid_data;
  logic [2*OB:0] out_data;
  logic          incoming;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (en) begin
      fv <= v_dx && v_dy;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (pay_dx[1]) begin
        fd <= '0;
      end else begin
        fd <= {1'b1, sat_push(SW'(qy), pay_dy), sat_push(SW'(qx), pay_dx[0])};
      end
    end
  end

  assign en       = !skid_valid;
  assign incoming = en && fv;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      skid_valid    <= 1'b0;
    end else if (!m_axis_tvalid || m_axis_tready) begin
      if (skid_valid) begin
        m_axis_tvalid <= 1'b1;
        skid_valid    <= 1'b0;
      end else begin
        m_axis_tvalid <= incoming;
      end
    end else if (incoming) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_axis_tvalid || m_axis_tready) begin
      out_data <= skid_valid ? skid_data : fd;
    end else if (incoming) begin
      skid_data <= fd;
    end
  end

  assign m_axis_tdata = out_data[2*OB-1:0];
  assign m_axis_tuser = out_data[2*OB];

  `CPV_ASSERT_IMP(a_skid_behind_out, skid_valid, m_axis_tvalid,
                  "skid entry held with no output pending")
  `CPV_ASSERT_IMP(a_miss_is_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == '0,
                  "nonzero push on a miss")
  `CPV_ASSERT_NXT(a_skid_drain, m_axis_tvalid && m_axis_tready && skid_valid,
                  m_axis_tvalid && (out_data == $past(skid_data)),
                  "skid entry not moved to output")
endmodule
